// File: design/vbm_pkg.sv
package vbm_pkg;

   localparam int MAX_X = 64;
   localparam int MAX_Y = 64;
   localparam int MAX_Z = 1024;

   localparam int SIZE_XY_W = 7;
   localparam int SIZE_Z_W  = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 11;

   localparam int COORD_X_W = (MAX_X > 1) ? $clog2(MAX_X) : 1;
   localparam int COORD_Y_W = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
   localparam int COORD_Z_W = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
   localparam int PLANE_W   = $clog2(MAX_X * MAX_Y + 1);
   localparam int TOTAL_W   = $clog2(MAX_X * MAX_Y * MAX_Z + 1);

   localparam int HOP_MAX    = MAX_X * MAX_Y - MAX_X;
   localparam int HOP_W      = (HOP_MAX > 1) ? $clog2(HOP_MAX + 1) : 1;
   localparam int CELL_DEPTH = (HOP_MAX > 2) ? HOP_MAX - 1 : 2;
   localparam int PTR_W      = $clog2(CELL_DEPTH);

   localparam int SETTLE_W = 2;
   localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Z = 2'd2;

   typedef enum logic [0:0] {
      CMD_PUSH  = 1'b0,
      CMD_DRAIN = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      CLASS_AIR      = 2'd0,
      CLASS_INTERIOR = 2'd1,
      CLASS_BOUNDARY = 2'd2
   } class_type;

   typedef struct packed {
      logic shift;
      logic restart;
      logic data;
   } chain_ctrl_type;

   typedef struct packed {
      logic center;
      logic x_plus;
      logic x_minus;
      logic y_plus;
      logic y_minus;
      logic z_plus;
      logic z_minus;
   } nbr_type;

endpackage

// File: design/vbm_if.sv
interface vbm_req_if;
   logic valid;
   logic ready;
   logic cmd;
   logic solid;

   modport source (output valid, output cmd, output solid, input ready);
   modport sink (input valid, input cmd, input solid, output ready);
endinterface

interface vbm_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] voxel_class;
   logic       last_voxel;

   modport source (output valid, output voxel_class, output last_voxel, input ready);
   modport sink (input valid, input voxel_class, input last_voxel, output ready);
endinterface

interface vbm_csr_if;
   logic                           valid;
   logic                           ready;
   logic [vbm_pkg::CSR_IDX_W-1:0] index;
   logic [vbm_pkg::CSR_DAT_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/vbm_cell.sv
module vbm_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  vbm_pkg::chain_ctrl_type     ctrl,
   input  logic [vbm_pkg::HOP_W-1:0]   hop,
   input  logic                        din,
   output logic                        dout
);

   logic                       ring_ff [vbm_pkg::CELL_DEPTH];
   logic [vbm_pkg::PTR_W-1:0] ptr_ff;
   logic [vbm_pkg::PTR_W-1:0] ptr_in;
   logic [vbm_pkg::PTR_W-1:0] ptr_last;
   logic                       rd_ff;
   logic                       hold_ff;

   assign ptr_last = vbm_pkg::PTR_W'(hop - vbm_pkg::HOP_W'(2));

   always_comb begin
      ptr_in = ptr_ff;
      if (ctrl.restart) begin
         ptr_in = '0;
      end else if (ctrl.shift && (hop > vbm_pkg::HOP_W'(1))) begin
         ptr_in = (ptr_ff == ptr_last) ? '0 : ptr_ff + vbm_pkg::PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         ring_ff[ptr_ff] <= din;
         rd_ff           <= ring_ff[ptr_ff];
         hold_ff         <= din;
      end
   end

   always_comb begin
      if (hop == '0) begin
         dout = din;
      end else if (hop == vbm_pkg::HOP_W'(1)) begin
         dout = hold_ff;
      end else begin
         dout = rd_ff;
      end
   end

endmodule

// File: design/vbm_chain.sv
module vbm_chain (
   input  logic                        clock,
   input  logic                        reset,
   input  vbm_pkg::chain_ctrl_type     ctrl,
   input  logic [vbm_pkg::HOP_W-1:0]   hop_plane,
   input  logic [vbm_pkg::HOP_W-1:0]   hop_row,
   output vbm_pkg::nbr_type            nbr
);

   logic newest_ff;
   logic tap_yp;
   logic tap_xp;
   logic tap_c;
   logic tap_xm;
   logic tap_ym;
   logic tap_zm;

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         newest_ff <= ctrl.data;
      end
   end

   vbm_cell u_cell_yp (
      .clock (clock), .reset (reset), .ctrl (ctrl),
      .hop (hop_plane), .din (newest_ff), .dout (tap_yp)
   );

   vbm_cell u_cell_xp (
      .clock (clock), .reset (reset), .ctrl (ctrl),
      .hop (hop_row), .din (tap_yp), .dout (tap_xp)
   );

   vbm_cell u_cell_c (
      .clock (clock), .reset (reset), .ctrl (ctrl),
      .hop (vbm_pkg::HOP_W'(1)), .din (tap_xp), .dout (tap_c)
   );

   vbm_cell u_cell_xm (
      .clock (clock), .reset (reset), .ctrl (ctrl),
      .hop (vbm_pkg::HOP_W'(1)), .din (tap_c), .dout (tap_xm)
   );

   vbm_cell u_cell_ym (
      .clock (clock), .reset (reset), .ctrl (ctrl),
      .hop (hop_row), .din (tap_xm), .dout (tap_ym)
   );

   vbm_cell u_cell_zm (
      .clock (clock), .reset (reset), .ctrl (ctrl),
      .hop (hop_plane), .din (tap_ym), .dout (tap_zm)
   );

   assign nbr.center  = tap_c;
   assign nbr.x_plus  = tap_xp;
   assign nbr.x_minus = tap_xm;
   assign nbr.y_plus  = tap_yp;
   assign nbr.y_minus = tap_ym;
   assign nbr.z_plus  = newest_ff;
   assign nbr.z_minus = tap_zm;

endmodule

// File: design/voxel_boundary_marker_unit.sv
// Classifies a raster-order voxel stream (x fastest, then y, then z) as air, interior or
// boundary under six-face connectivity, accepting one item per clock cycle unless stalled.
// Each voxel passes through a chain of delay cells whose lengths follow the grid sizes, so
// a voxel's class is delivered once its upper z neighbor has arrived, one plane after it
// was pushed. Drain items flush the last plane. A push within the grid or an emitting
// drain moves the chain by one position. Intake stalls only on the result handshake
// and, after a size register write, while the plane and grid sizes are recomputed.
// Plane buffers need no clearing pass after reset.
module voxel_boundary_marker_unit (
   input  logic  clock,
   input  logic  reset,
   vbm_req_if.sink   req_if,
   vbm_rsp_if.source rsp_if,
   vbm_csr_if.sink   csr_if
);

   logic [vbm_pkg::SIZE_XY_W-1:0] nx_ff;
   logic [vbm_pkg::SIZE_XY_W-1:0] ny_ff;
   logic [vbm_pkg::SIZE_Z_W-1:0]  nz_ff;
   logic [vbm_pkg::PLANE_W-1:0]   plane_ff;
   logic [vbm_pkg::TOTAL_W-1:0]   total_ff;
   logic [vbm_pkg::HOP_W-1:0]     hop_plane_ff;
   logic [vbm_pkg::HOP_W-1:0]     hop_row_ff;
   logic [vbm_pkg::SETTLE_W-1:0]  settle_ff;

   logic [vbm_pkg::TOTAL_W-1:0]   pushed_ff;
   logic [vbm_pkg::TOTAL_W-1:0]   pushed_in;
   logic [vbm_pkg::COORD_X_W-1:0] x_ff;
   logic [vbm_pkg::COORD_X_W-1:0] x_in;
   logic [vbm_pkg::COORD_Y_W-1:0] y_ff;
   logic [vbm_pkg::COORD_Y_W-1:0] y_in;
   logic [vbm_pkg::COORD_Z_W-1:0] z_ff;
   logic [vbm_pkg::COORD_Z_W-1:0] z_in;

   logic s1_valid_ff;
   logic s1_valid_in;
   logic s1_edge_ff;
   logic s1_last_ff;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic [1:0] rsp_class_ff;
   logic rsp_last_ff;

   logic [vbm_pkg::SIZE_XY_W-1:0] csr_xy;
   logic [vbm_pkg::SIZE_Z_W-1:0]  csr_z;
   logic csr_acc;
   logic csr_write;
   logic acc;
   logic is_push;
   logic push_ok;
   logic drain_ok;
   logic emit;
   logic s1_go;
   logic x_end;
   logic y_end;
   logic z_end;
   logic cur_edge;
   logic cur_last;
   vbm_pkg::class_type     cls;
   vbm_pkg::chain_ctrl_type ctrl;
   vbm_pkg::nbr_type        nbr;

   assign csr_if.ready = 1'b1;
   assign csr_acc      = csr_if.valid;
   assign csr_write    = csr_acc && ((csr_if.index == vbm_pkg::REG_SIZE_X) ||
                                     (csr_if.index == vbm_pkg::REG_SIZE_Y) ||
                                     (csr_if.index == vbm_pkg::REG_SIZE_Z));

   always_comb begin
      csr_xy = csr_if.data[vbm_pkg::SIZE_XY_W-1:0];
      if (csr_xy == '0) begin
         csr_xy = vbm_pkg::SIZE_XY_W'(1);
      end
      csr_z = csr_if.data[vbm_pkg::SIZE_Z_W-1:0];
      if (csr_z == '0) begin
         csr_z = vbm_pkg::SIZE_Z_W'(1);
      end else if (csr_z > vbm_pkg::SIZE_Z_W'(vbm_pkg::MAX_Z)) begin
         csr_z = vbm_pkg::SIZE_Z_W'(vbm_pkg::MAX_Z);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff     <= vbm_pkg::SIZE_XY_W'(64);
         ny_ff     <= vbm_pkg::SIZE_XY_W'(64);
         nz_ff     <= vbm_pkg::SIZE_Z_W'(64);
         settle_ff <= vbm_pkg::SETTLE_CYCLES;
      end else begin
         if (csr_acc) begin
            unique case (csr_if.index)
               vbm_pkg::REG_SIZE_X: nx_ff <= (csr_xy > vbm_pkg::SIZE_XY_W'(vbm_pkg::MAX_X)) ?
                                             vbm_pkg::SIZE_XY_W'(vbm_pkg::MAX_X) : csr_xy;
               vbm_pkg::REG_SIZE_Y: ny_ff <= (csr_xy > vbm_pkg::SIZE_XY_W'(vbm_pkg::MAX_Y)) ?
                                             vbm_pkg::SIZE_XY_W'(vbm_pkg::MAX_Y) : csr_xy;
               vbm_pkg::REG_SIZE_Z: nz_ff <= csr_z;
               default: ;
            endcase
         end
         if (csr_write) begin
            settle_ff <= vbm_pkg::SETTLE_CYCLES;
         end else if (settle_ff != '0) begin
            settle_ff <= settle_ff - vbm_pkg::SETTLE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      plane_ff     <= vbm_pkg::PLANE_W'(vbm_pkg::PLANE_W'(nx_ff) * vbm_pkg::PLANE_W'(ny_ff));
      total_ff     <= vbm_pkg::TOTAL_W'(vbm_pkg::TOTAL_W'(plane_ff) * vbm_pkg::TOTAL_W'(nz_ff));
      hop_plane_ff <= vbm_pkg::HOP_W'(plane_ff - vbm_pkg::PLANE_W'(nx_ff));
      hop_row_ff   <= vbm_pkg::HOP_W'(nx_ff - vbm_pkg::SIZE_XY_W'(1));
   end

   assign s1_go        = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (settle_ff == '0) && (!s1_valid_ff || s1_go);
   assign acc          = req_if.valid && req_if.ready;
   assign is_push      = (req_if.cmd == vbm_pkg::CMD_PUSH);
   assign push_ok      = is_push && (pushed_ff < total_ff);
   assign drain_ok     = !is_push && (pushed_ff == total_ff);
   assign emit         = acc && ((push_ok && (pushed_ff >= vbm_pkg::TOTAL_W'(plane_ff)))
                                 || drain_ok);

   assign ctrl.shift   = acc && (push_ok || drain_ok);
   assign ctrl.restart = csr_write;
   assign ctrl.data    = is_push && req_if.solid;

   assign x_end    = (vbm_pkg::SIZE_XY_W'(x_ff) == nx_ff - vbm_pkg::SIZE_XY_W'(1));
   assign y_end    = (vbm_pkg::SIZE_XY_W'(y_ff) == ny_ff - vbm_pkg::SIZE_XY_W'(1));
   assign z_end    = (vbm_pkg::SIZE_Z_W'(z_ff) == nz_ff - vbm_pkg::SIZE_Z_W'(1));
   assign cur_edge = (x_ff == '0) || (y_ff == '0) || (z_ff == '0) || x_end || y_end || z_end;
   assign cur_last = x_end && y_end && z_end;

   always_comb begin
      pushed_in = pushed_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      if (csr_write) begin
         pushed_in = '0;
         x_in      = '0;
         y_in      = '0;
         z_in      = '0;
      end else begin
         if (acc && push_ok) begin
            pushed_in = pushed_ff + vbm_pkg::TOTAL_W'(1);
         end
         if (emit) begin
            if (cur_last) begin
               pushed_in = '0;
               x_in      = '0;
               y_in      = '0;
               z_in      = '0;
            end else if (!x_end) begin
               x_in = x_ff + vbm_pkg::COORD_X_W'(1);
            end else begin
               x_in = '0;
               if (!y_end) begin
                  y_in = y_ff + vbm_pkg::COORD_Y_W'(1);
               end else begin
                  y_in = '0;
                  z_in = z_ff + vbm_pkg::COORD_Z_W'(1);
               end
            end
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (emit) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_valid_ff && s1_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      if (!nbr.center) begin
         cls = vbm_pkg::CLASS_AIR;
      end else if (s1_edge_ff || !nbr.x_plus || !nbr.x_minus || !nbr.y_plus ||
                   !nbr.y_minus || !nbr.z_plus || !nbr.z_minus) begin
         cls = vbm_pkg::CLASS_BOUNDARY;
      end else begin
         cls = vbm_pkg::CLASS_INTERIOR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pushed_ff    <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         z_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pushed_ff    <= pushed_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         z_ff         <= z_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         s1_edge_ff <= cur_edge;
         s1_last_ff <= cur_last;
      end
      if (s1_valid_ff && s1_go) begin
         rsp_class_ff <= cls;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   vbm_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .hop_plane (hop_plane_ff),
      .hop_row   (hop_row_ff),
      .nbr       (nbr)
   );

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.voxel_class = rsp_class_ff;
   assign rsp_if.last_voxel  = rsp_last_ff;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int RING_DEPTH = 2 * vbm_pkg::MAX_X * vbm_pkg::MAX_Y + 1;
   localparam int CYCLE_LIMIT = 40000;
   localparam int QUIET_CYCLES = 16;
   localparam int RANDOM_ITEMS = 550;
   localparam logic [vbm_pkg::CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct {
      vbm_pkg::class_type voxel_class;
      logic               last_voxel;
   } voxel_result_type;

   class voxel_scoreboard_type;
      bit               occupancy [RING_DEPTH];
      int unsigned      pushed;
      int unsigned      emitted;
      int unsigned      cur_x;
      int unsigned      cur_y;
      int unsigned      cur_z;
      logic [6:0]       reg_x;
      logic [6:0]       reg_y;
      logic [10:0]      reg_z;
      voxel_result_type expected_q[$];
      int               errors;

      function new();
         reg_x = 7'd64;
         reg_y = 7'd64;
         reg_z = 11'd64;
         errors = 0;
         restart();
      endfunction

      function void restart();
         pushed = 0;
         emitted = 0;
         cur_x = 0;
         cur_y = 0;
         cur_z = 0;
      endfunction

      function int unsigned saturate(int unsigned v, int unsigned hi);
         if (v < 1) return 1;
         if (v > hi) return hi;
         return v;
      endfunction

      function int unsigned dim_x();
         return saturate(reg_x, vbm_pkg::MAX_X);
      endfunction

      function int unsigned dim_y();
         return saturate(reg_y, vbm_pkg::MAX_Y);
      endfunction

      function int unsigned dim_z();
         return saturate(reg_z, vbm_pkg::MAX_Z);
      endfunction

      function int unsigned plane_size();
         return dim_x() * dim_y();
      endfunction

      function int unsigned grid_total();
         return plane_size() * dim_z();
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function bit ring_bit(int unsigned pos);
         return occupancy[pos % RING_DEPTH];
      endfunction

      function void write_reg(logic [vbm_pkg::CSR_IDX_W-1:0] index,
                              logic [vbm_pkg::CSR_DAT_W-1:0] data);
         case (index)
            vbm_pkg::REG_SIZE_X: reg_x = data[6:0];
            vbm_pkg::REG_SIZE_Y: reg_y = data[6:0];
            vbm_pkg::REG_SIZE_Z: reg_z = data[10:0];
            default: return;
         endcase
         restart();
      endfunction

      function void classify_next();
         int unsigned      nx;
         int unsigned      ny;
         int unsigned      nz;
         int unsigned      plane;
         int unsigned      total;
         int unsigned      e;
         bit               on_edge;
         voxel_result_type res;
         nx = dim_x();
         ny = dim_y();
         nz = dim_z();
         plane = nx * ny;
         total = plane * nz;
         e = emitted;
         res.voxel_class = vbm_pkg::CLASS_AIR;
         if (ring_bit(e)) begin
            on_edge = cur_x == 0 || cur_y == 0 || cur_z == 0 ||
                      cur_x == nx - 1 || cur_y == ny - 1 || cur_z == nz - 1;
            if (on_edge || !ring_bit(e + 1) || !ring_bit(e - 1) || !ring_bit(e + nx) ||
                !ring_bit(e - nx) || !ring_bit(e + plane) || !ring_bit(e - plane)) begin
               res.voxel_class = vbm_pkg::CLASS_BOUNDARY;
            end else begin
               res.voxel_class = vbm_pkg::CLASS_INTERIOR;
            end
         end
         res.last_voxel = (e + 1 == total);
         expected_q = {expected_q, res};
         emitted = e + 1;
         if (emitted >= total) begin
            restart();
            return;
         end
         cur_x++;
         if (cur_x >= nx) begin
            cur_x = 0;
            cur_y++;
            if (cur_y >= ny) begin
               cur_y = 0;
               cur_z++;
            end
         end
      endfunction

      function void note_item(vbm_pkg::cmd_type cmd, bit solid);
         int unsigned plane;
         int unsigned total;
         plane = plane_size();
         total = grid_total();
         if (cmd == vbm_pkg::CMD_PUSH) begin
            if (pushed >= total) return;
            occupancy[pushed % RING_DEPTH] = solid;
            pushed++;
            if (emitted + plane < pushed) classify_next();
         end else if (pushed >= total && emitted < total) begin
            classify_next();
         end
      endfunction

      function void check_result(logic [1:0] voxel_class, logic last_voxel);
         voxel_result_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected result: voxel_class=%0d last_voxel=%0d", voxel_class,
                   last_voxel);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (voxel_class !== want.voxel_class) begin
            $error("voxel_class: expected %0d, actual %0d", want.voxel_class, voxel_class);
            errors++;
         end
         if (last_voxel !== want.last_voxel) begin
            $error("last_voxel: expected %0d, actual %0d", want.last_voxel, last_voxel);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   steady_run;
   int   cycle_count = 0;
   int   random_items;

   vbm_req_if req_bus ();
   vbm_rsp_if rsp_bus ();
   vbm_csr_if csr_bus ();

   voxel_scoreboard_type sb = new();

   voxel_boundary_marker_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always #10 clock = ~clock;

   function automatic bit idle_roll();
      return !steady_run && ($urandom_range(99) < 31);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) sb.write_reg(csr_bus.index, csr_bus.data);
         if (req_bus.valid && req_bus.ready) begin
            sb.note_item(vbm_pkg::cmd_type'(req_bus.cmd), req_bus.solid);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_result(rsp_bus.voxel_class, rsp_bus.last_voxel);
         end
      end
   end

   always @(posedge clock) begin
      rsp_bus.ready <= reset ? 1'b0 : !idle_roll();
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_item(vbm_pkg::cmd_type cmd, bit solid);
      while (idle_roll()) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= cmd;
      req_bus.solid <= solid;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic wait_quiet();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [vbm_pkg::CSR_IDX_W-1:0] index,
                            logic [vbm_pkg::CSR_DAT_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
   endtask

   task automatic set_sizes(int unsigned sx, int unsigned sy, int unsigned sz, bit spare);
      wait_quiet();
      write_csr(vbm_pkg::REG_SIZE_X, {4'($urandom_range(15)), 7'(sx)});
      write_csr(vbm_pkg::REG_SIZE_Y, {4'($urandom_range(15)), 7'(sy)});
      write_csr(vbm_pkg::REG_SIZE_Z, 11'(sz));
      if (spare) write_csr(REG_UNUSED, 11'($urandom_range(2047)));
      csr_bus.valid <= 1'b0;
   endtask

   task automatic run_grid(int unsigned density, bit noisy, bit may_break);
      int unsigned total;
      int unsigned plane;
      int unsigned stop_at;
      total = sb.grid_total();
      plane = sb.plane_size();
      stop_at = total;
      if (may_break && $urandom_range(3) == 0) stop_at = $urandom_range(total - 1);
      for (int unsigned v = 0; v < stop_at; v++) begin
         if (noisy && $urandom_range(99) < 6) send_item(vbm_pkg::CMD_DRAIN, 1'($urandom_range(1)));
         send_item(vbm_pkg::CMD_PUSH, $urandom_range(99) < density);
         random_items++;
      end
      if (stop_at < total) return;
      if (noisy) repeat ($urandom_range(3)) send_item(vbm_pkg::CMD_PUSH, 1'($urandom_range(1)));
      for (int unsigned v = 0; v < plane; v++) begin
         send_item(vbm_pkg::CMD_DRAIN, 1'($urandom_range(1)));
         random_items++;
      end
      if (noisy) repeat ($urandom_range(2)) send_item(vbm_pkg::CMD_DRAIN, 1'($urandom_range(1)));
   endtask

   initial begin
      int unsigned sx;
      int unsigned sy;
      int unsigned sz;
      int unsigned grids;
      int unsigned density;
      bit          noisy;
      reset = 1'b1;
      steady_run = 1'b0;
      random_items = 0;
      req_bus.valid = 1'b0;
      req_bus.cmd = vbm_pkg::CMD_PUSH;
      req_bus.solid = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = vbm_pkg::REG_SIZE_X;
      csr_bus.data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset sizes: an early drain is ignored and the first pushes produce nothing yet.
      send_item(vbm_pkg::CMD_DRAIN, 1'b1);
      send_item(vbm_pkg::CMD_PUSH, 1'b1);
      send_item(vbm_pkg::CMD_PUSH, 1'b0);

      // Single voxel grid; zero sizes count as one.
      set_sizes(0, 1, 0, 1'b1);
      send_item(vbm_pkg::CMD_PUSH, 1'b1);
      send_item(vbm_pkg::CMD_PUSH, 1'b0);
      send_item(vbm_pkg::CMD_DRAIN, 1'b0);
      send_item(vbm_pkg::CMD_DRAIN, 1'b1);

      // A solid cube whose center voxel is interior.
      set_sizes(3, 3, 3, 1'b0);
      repeat (27) send_item(vbm_pkg::CMD_PUSH, 1'b1);
      repeat (10) send_item(vbm_pkg::CMD_DRAIN, 1'b0);

      set_sizes(1, 1, 2047, 1'b0);
      run_grid(50, 1'b0, 1'b0);
      set_sizes(64, 1, 1024, 1'b0);
      set_sizes(4, 5, 1, 1'b0);
      run_grid(70, 1'b1, 1'b0);

      steady_run = 1'b1;
      set_sizes(9, 7, 2, 1'b0);
      run_grid(97, 1'b0, 1'b0);
      steady_run = 1'b0;

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         sx = $urandom_range(6);
         sy = $urandom_range(6);
         sz = $urandom_range(6);
         grids = $urandom_range(3, 1);
         case ($urandom_range(11))
            0: begin
               sx = $urandom_range(127, 7);
               sy = $urandom_range(2);
               sz = $urandom_range(2);
               grids = 1;
            end
            1: begin
               sy = $urandom_range(127, 7);
               sx = $urandom_range(2);
               sz = $urandom_range(2);
               grids = 1;
            end
            2: begin
               sz = $urandom_range(40, 7);
               sx = $urandom_range(2);
               sy = $urandom_range(2);
               grids = 1;
            end
            default: ;
         endcase
         set_sizes(sx, sy, sz, $urandom_range(15) == 0);
         case ($urandom_range(3))
            0: density = 50;
            1: density = 85;
            2: density = 95;
            default: density = 100;
         endcase
         noisy = $urandom_range(99) < 30;
         for (int unsigned g = 0; g < grids; g++) begin
            run_grid(density, noisy, noisy && g == grids - 1);
         end
      end

      wait_quiet();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: voxel_boundary_marker_unit.f
design/vbm_pkg.sv
design/vbm_if.sv
design/vbm_cell.sv
design/vbm_chain.sv
design/voxel_boundary_marker_unit.sv
tb/tb_top.sv
